// ----- design/box_filter_mip_chain_macros.svh -----
// Assertion macros for the box filter mip chain.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef BOX_FILTER_MIP_CHAIN_MACROS_SVH
`define BOX_FILTER_MIP_CHAIN_MACROS_SVH

// Same-cycle implication, silent during reset
`define BFMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, silent during reset
`define BFMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bfmc_pkg.sv -----
// Shared widths and defaults for the box filter mip chain.
// No dependencies; imported by the top level and the testbench.
package bfmc_pkg;

   localparam int PIXEL_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int LEVEL_W  = 4;
   localparam int COORD_W  = 8;
   localparam int OFFSET_W = 17;
   localparam int CFG_W    = 4;

   localparam int MAX_WIDTH_LOG2_DEF = 8;
   localparam logic [CFG_W-1:0] WIDTH_LOG2_RST = 4'd8;

endpackage

// ----- design/box_filter_mip_chain.sv -----
// Box filter mip chain generator: raster pixels in, all mip levels out.
// Depends on bfmc_pkg and box_filter_mip_chain_macros.svh.
//
// Takes a square 2^n by 2^n image (n = width_log2, clamped to MAX_WIDTH_LOG2)
// one 24-bit RGB pixel per transfer in raster order and returns the level-0
// pixel followed by every higher-level pixel whose box that source pixel
// completes, in increasing level order, the final one flagged last_of_run.
// Each pixel is worked through by a level sequencer that visits levels 0..n
// one per cycle while the result side does not stall, doing a read-modify-write
// of the column sums of levels above 0 in a single sum memory (one read port,
// one write port, registered read data). The next pixel is taken once the
// previous one's last level has been written back. The sum memory needs no
// clearing pass: every box overwrites its entry first.
// Writing width_log2 restarts the image at the top-left corner.
module box_filter_mip_chain #(
   parameter int MAX_WIDTH_LOG2 = bfmc_pkg::MAX_WIDTH_LOG2_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [bfmc_pkg::CFG_W-1:0]    csr_wr_data,
   // source pixels
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bfmc_pkg::PIXEL_W-1:0]  req_pixel,
   // mip pixels
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfmc_pkg::PIXEL_W-1:0]  rsp_color,
   output logic [bfmc_pkg::LEVEL_W-1:0]  rsp_level,
   output logic [bfmc_pkg::COORD_W-1:0]  rsp_col,
   output logic [bfmc_pkg::COORD_W-1:0]  rsp_row,
   output logic [bfmc_pkg::OFFSET_W-1:0] rsp_offset,
   output logic                          rsp_last_of_run
);
   import bfmc_pkg::*;
   `include "box_filter_mip_chain_macros.svh"

   localparam int X_W   = MAX_WIDTH_LOG2;       // coordinate / index width
   localparam int W_W   = MAX_WIDTH_LOG2 + 1;   // holds the image width itself
   localparam int OFF_W = 2 * MAX_WIDTH_LOG2 + 2;
   localparam int SUM_W = CHAN_W + 2 * MAX_WIDTH_LOG2;
   localparam int DEPTH = 1 << MAX_WIDTH_LOG2;

   // ---------------------------------------------------------------
   // Configuration and image position
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] width_log2_ff;
   logic [CFG_W-1:0] n_eff;
   logic [W_W-1:0]   img_w;
   logic [X_W-1:0]   coord_mask;
   logic [X_W-1:0]   pos_x_ff, pos_x_in;
   logic [X_W-1:0]   pos_y_ff, pos_y_in;
   logic [X_W-1:0]   acc_x, acc_y;
   logic [W_W-1:0]   x_inc, y_inc;
   logic             req_fire;

   assign n_eff      = (width_log2_ff > CFG_W'(MAX_WIDTH_LOG2)) ?
                       CFG_W'(MAX_WIDTH_LOG2) : width_log2_ff;
   assign img_w      = W_W'(1) << n_eff;
   assign coord_mask = X_W'(img_w - W_W'(1));
   assign acc_x      = pos_x_ff & coord_mask;
   assign acc_y      = pos_y_ff & coord_mask;

   logic busy_ff, busy_in;
   assign req_stall = busy_ff;
   assign req_fire  = req_valid && !busy_ff;

   // raster advance with wrap at the end of a row and of the image
   assign x_inc = W_W'(acc_x) + W_W'(1);
   assign y_inc = W_W'(acc_y) + W_W'(1);
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (csr_wr_en) begin
         pos_x_in = '0;
         pos_y_in = '0;
      end else if (req_fire) begin
         if (x_inc >= img_w) begin
            pos_x_in = '0;
            pos_y_in = (y_inc >= img_w) ? '0 : X_W'(y_inc);
         end else begin
            pos_x_in = X_W'(x_inc);
            pos_y_in = acc_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff <= WIDTH_LOG2_RST;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
      end else begin
         if (csr_wr_en) width_log2_ff <= csr_wr_data;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // current pixel, held for the whole level sweep
   logic [PIXEL_W-1:0] cur_pixel_ff;
   logic [X_W-1:0]     cur_x_ff, cur_y_ff;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_pixel_ff <= req_pixel;
         cur_x_ff     <= acc_x;
         cur_y_ff     <= acc_y;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------
   // Issue stage: one level per cycle unless the output stalls; reads sums here
   // ---------------------------------------------------------------
   logic                iss_valid_ff, iss_valid_in;
   logic [LEVEL_W-1:0]  iss_lvl_ff, iss_lvl_in;
   logic [OFF_W-1:0]    iss_off_ff, iss_off_in;

   logic [X_W-1:0]      lvl_mask, nxt_mask;
   logic [X_W-1:0]      iss_col, iss_row;
   logic [W_W-1:0]      lvl_base;
   logic [X_W-1:0]      iss_idx;
   logic                iss_first, iss_emit, iss_last;
   logic [OFF_W-1:0]    iss_offset;
   logic                adv;

   assign lvl_mask = X_W'((W_W'(1) << iss_lvl_ff) - W_W'(1));
   assign nxt_mask = X_W'((W_W'(1) << (iss_lvl_ff + LEVEL_W'(1))) - W_W'(1));
   assign iss_col  = cur_x_ff >> iss_lvl_ff;
   assign iss_row  = cur_y_ff >> iss_lvl_ff;
   // level L columns sit at W - (W >> (L-1)) upwards
   assign lvl_base = img_w - (img_w >> (iss_lvl_ff - LEVEL_W'(1)));
   assign iss_idx  = X_W'(lvl_base + W_W'(iss_col));

   assign iss_first = ((cur_x_ff & lvl_mask) == '0) && ((cur_y_ff & lvl_mask) == '0);
   assign iss_emit  = ((cur_x_ff & lvl_mask) == lvl_mask) &&
                      ((cur_y_ff & lvl_mask) == lvl_mask);
   // the run ends here unless the next level's box completes too
   assign iss_last  = (iss_lvl_ff == n_eff) ||
                      !(((cur_x_ff & nxt_mask) == nxt_mask) &&
                        ((cur_y_ff & nxt_mask) == nxt_mask));
   assign iss_offset = iss_off_ff + OFF_W'(iss_col) +
                       (OFF_W'(iss_row) << (n_eff - iss_lvl_ff));

   // ---------------------------------------------------------------
   // Update stage: add into the read sums, write back, emit
   // ---------------------------------------------------------------
   logic               upd_valid_ff, upd_valid_in;
   logic [LEVEL_W-1:0] upd_lvl_ff;
   logic               upd_first_ff, upd_emit_ff, upd_last_ff;
   logic [X_W-1:0]     upd_idx_ff, upd_col_ff, upd_row_ff;
   logic [OFF_W-1:0]   upd_offset_ff;

   // sequencer moves unless a result is waiting on a stalled output
   assign adv = !upd_valid_ff || !upd_emit_ff || out_free;

   always_comb begin
      iss_valid_in = iss_valid_ff;
      iss_lvl_in   = iss_lvl_ff;
      iss_off_in   = iss_off_ff;
      if (req_fire) begin
         iss_valid_in = 1'b1;
         iss_lvl_in   = '0;
         iss_off_in   = '0;
      end else if (adv && iss_valid_ff) begin
         iss_valid_in = (iss_lvl_ff != n_eff);
         iss_lvl_in   = iss_lvl_ff + LEVEL_W'(1);
         // next level starts after (W >> L)^2 entries of this one
         iss_off_in   = iss_off_ff +
                        (OFF_W'(1) << {5'(n_eff - iss_lvl_ff), 1'b0});
      end
   end

   assign upd_valid_in = adv ? iss_valid_ff : upd_valid_ff;

   always_comb begin
      busy_in = busy_ff;
      if (req_fire)
         busy_in = 1'b1;
      else if (adv && upd_valid_ff && (upd_lvl_ff == n_eff))
         busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         iss_valid_ff <= 1'b0;
         upd_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         iss_valid_ff <= iss_valid_in;
         upd_valid_ff <= upd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_lvl_ff <= iss_lvl_in;
      iss_off_ff <= iss_off_in;
      if (adv) begin
         upd_lvl_ff    <= iss_lvl_ff;
         upd_first_ff  <= iss_first;
         upd_emit_ff   <= iss_emit;
         upd_last_ff   <= iss_last;
         upd_idx_ff    <= iss_idx;
         upd_col_ff    <= iss_col;
         upd_row_ff    <= iss_row;
         upd_offset_ff <= iss_offset;
      end
   end

   // ---------------------------------------------------------------
   // Sum memory: red, green, blue sums side by side
   // ---------------------------------------------------------------
   logic [3*SUM_W-1:0] sum_mem [DEPTH];
   logic [3*SUM_W-1:0] rd_data_ff;
   logic [3*SUM_W-1:0] wr_data;
   logic               rd_en, wr_en;

   assign rd_en = adv && iss_valid_ff && (iss_lvl_ff != '0);
   assign wr_en = adv && upd_valid_ff && (upd_lvl_ff != '0);

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= sum_mem[iss_idx];
      if (wr_en) sum_mem[upd_idx_ff] <= wr_data;
   end

   // accumulate: a box's first pixel overwrites its entry
   logic [SUM_W-1:0] old_r, old_g, old_b;
   logic [SUM_W-1:0] new_r, new_g, new_b;
   logic [SUM_W-1:0] px_r, px_g, px_b;
   logic [5:0]       avg_sh;
   logic [PIXEL_W-1:0] upd_color;

   assign {old_r, old_g, old_b} = rd_data_ff;
   assign px_r = SUM_W'(cur_pixel_ff[23:16]);
   assign px_g = SUM_W'(cur_pixel_ff[15:8]);
   assign px_b = SUM_W'(cur_pixel_ff[7:0]);
   assign new_r = upd_first_ff ? px_r : old_r + px_r;
   assign new_g = upd_first_ff ? px_g : old_g + px_g;
   assign new_b = upd_first_ff ? px_b : old_b + px_b;
   assign wr_data = {new_r, new_g, new_b};

   // average over 4^L pixels is a right shift by 2L
   assign avg_sh = {1'b0, upd_lvl_ff, 1'b0};
   assign upd_color = (upd_lvl_ff == '0) ? cur_pixel_ff :
                      {CHAN_W'(new_r >> avg_sh), CHAN_W'(new_g >> avg_sh),
                       CHAN_W'(new_b >> avg_sh)};

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic load_rsp;
   assign load_rsp = adv && upd_valid_ff && upd_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_color       <= upd_color;
         rsp_level       <= upd_lvl_ff;
         rsp_col         <= COORD_W'(upd_col_ff);
         rsp_row         <= COORD_W'(upd_row_ff);
         rsp_offset      <= OFFSET_W'(upd_offset_ff);
         rsp_last_of_run <= upd_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `BFMC_ASSERT_NOW(a_idle_pipe_empty, !busy_ff, !iss_valid_ff && !upd_valid_ff, "pipeline active while idle")
   `BFMC_ASSERT_NOW(a_no_rw_clash, rd_en && wr_en, iss_idx != upd_idx_ff, "sum read and write hit one entry")
   `BFMC_ASSERT_NEXT(a_level_in_range, load_rsp, rsp_level <= n_eff, "result level above image depth")

endmodule

// ----- tb/box_filter_mip_chain_tb.sv -----
// Self-checking testbench for box_filter_mip_chain: streams raster images, predicts every
// mip pixel (level, position, offset, truncated box average) and checks each transfer.
// Depends on bfmc_pkg and the design top level; needs no other files.
module box_filter_mip_chain_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfmc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int SUM_ENTRIES    = 1 << MAX_WIDTH_LOG2_DEF;

   typedef struct packed {
      logic [PIXEL_W-1:0]  color;
      logic [LEVEL_W-1:0]  level;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [OFFSET_W-1:0] offset;
      logic                last_of_run;
   } mip_pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PIXEL_W-1:0]  req_pixel = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]  rsp_color;
   logic [LEVEL_W-1:0]  rsp_level;
   logic [COORD_W-1:0]  rsp_col;
   logic [COORD_W-1:0]  rsp_row;
   logic [OFFSET_W-1:0] rsp_offset;
   logic                rsp_last_of_run;

   // predictor state
   logic [CFG_W-1:0] cur_width_log2 = WIDTH_LOG2_RST;
   int unsigned      pos_x = 0;
   int unsigned      pos_y = 0;
   logic [31:0]      box_red   [SUM_ENTRIES];
   logic [31:0]      box_green [SUM_ENTRIES];
   logic [31:0]      box_blue  [SUM_ENTRIES];
   mip_pixel_type    mip_expected [$];

   // run control and tallies
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int top_level_seen = 0;

   box_filter_mip_chain i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_color       (rsp_color),
      .rsp_level       (rsp_level),
      .rsp_col         (rsp_col),
      .rsp_row         (rsp_row),
      .rsp_offset      (rsp_offset),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #1ns clock = ~clock;

   // Work out every mip pixel that one source pixel produces and queue them
   function automatic void predict_mip_pixels(input logic [PIXEL_W-1:0] px);
      mip_pixel_type run [0:8];
      int            cnt;
      int unsigned   n, w, x, y, lvl, lvl_off, m, lw, base, idx, sh, i;
      logic [7:0]    pr, pg, pb, rr, gg, bb;
      cnt = 0;
      n = (cur_width_log2 > CFG_W'(MAX_WIDTH_LOG2_DEF)) ? MAX_WIDTH_LOG2_DEF :
                                                          32'(cur_width_log2);
      w = 1 << n;
      x = pos_x;
      y = pos_y;
      pr = px[23:16];
      pg = px[15:8];
      pb = px[7:0];
      lvl_off = w * w;
      // full-size pixel passes straight through
      run[0].color       = px;
      run[0].level       = '0;
      run[0].col         = COORD_W'(x);
      run[0].row         = COORD_W'(y);
      run[0].offset      = OFFSET_W'(x + y * w);
      run[0].last_of_run = 1'b0;
      cnt = 1;
      for (lvl = 1; lvl <= n; lvl++) begin
         m    = (1 << lvl) - 1;
         lw   = w >> lvl;
         base = w - (w >> (lvl - 1));
         idx  = (base + (x >> lvl)) % SUM_ENTRIES;
         // first pixel of a box overwrites its column sum
         if ((x & m) == 0 && (y & m) == 0) begin
            box_red[idx]   = 32'(pr);
            box_green[idx] = 32'(pg);
            box_blue[idx]  = 32'(pb);
         end else begin
            box_red[idx]   = box_red[idx] + 32'(pr);
            box_green[idx] = box_green[idx] + 32'(pg);
            box_blue[idx]  = box_blue[idx] + 32'(pb);
         end
         // last pixel of a box: truncating average
         if ((x & m) == m && (y & m) == m) begin
            sh = 2 * lvl;
            rr = 8'(box_red[idx] >> sh);
            gg = 8'(box_green[idx] >> sh);
            bb = 8'(box_blue[idx] >> sh);
            run[cnt].color       = {rr, gg, bb};
            run[cnt].level       = LEVEL_W'(lvl);
            run[cnt].col         = COORD_W'(x >> lvl);
            run[cnt].row         = COORD_W'(y >> lvl);
            run[cnt].offset      = OFFSET_W'(lvl_off + (x >> lvl) + (y >> lvl) * lw);
            run[cnt].last_of_run = 1'b0;
            cnt++;
         end
         lvl_off += lw * lw;
      end
      run[cnt-1].last_of_run = 1'b1;
      for (i = 0; i < cnt; i++)
         mip_expected.push_back(run[i]);
      // raster advance with wrap at the end of the image
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= w)
            y = 0;
      end
      pos_x = x;
      pos_y = y;
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [PIXEL_W-1:0] px;
      case ($urandom_range(7))
         0: px = '1;
         1: px = '0;
         2: px = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                  {8{1'($urandom_range(1))}}};
         default: px = PIXEL_W'($urandom);
      endcase
      return px;
   endfunction

   // Offer one pixel, with random idle cycles first, and wait for its transfer
   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      predict_mip_pixels(px);
      pixels_sent++;
   endtask

   // Stop offering, let every expected result arrive and the sequencer settle
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mip_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write while idle; any write restarts the image
   task automatic write_width(input logic [CFG_W-1:0] val);
      drain_block();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_width_log2 = val;
      pos_x = 0;
      pos_y = 0;
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                     field, results_seen, want, got);
      end
   endtask

   // Compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      mip_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mip_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: level %0d col %0d row %0d color 0x%06h",
                        rsp_level, rsp_col, rsp_row, rsp_color);
         end else begin
            want = mip_expected.pop_front();
            check_field("color", 32'(want.color), 32'(rsp_color));
            check_field("level", 32'(want.level), 32'(rsp_level));
            check_field("col", 32'(want.col), 32'(rsp_col));
            check_field("row", 32'(want.row), 32'(rsp_row));
            check_field("offset", 32'(want.offset), 32'(rsp_offset));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
         end
         if (int'(rsp_level) > top_level_seen)
            top_level_seen = int'(rsp_level);
         results_seen++;
      end
   end

   // Watchdog: too long without any transfer ends the run
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Width from reset, full-size pixels only within the first row
   task automatic test_reset_width();
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h00FF00);
      send_pixel(24'hA5C35A);
   endtask

   // One-pixel image: every pixel lands at offset 0 and is its own last
   task automatic test_single_pixel();
      write_width(4'd0);
      send_pixel(24'h123456);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
   endtask

   // Width above the maximum is clamped
   task automatic test_oversized_width();
      write_width(4'd15);
      send_pixel(24'h5A5A5A);
      send_pixel(24'hFF00FF);
   endtask

   // 2x2 images: full-scale pixels, then truncation to zero, across the image wrap
   task automatic test_box_average();
      int i;
      write_width(4'd1);
      for (i = 0; i < 4; i++)
         send_pixel(24'hFFFFFF);
      send_pixel(24'h030303);
      for (i = 0; i < 3; i++)
         send_pixel(24'h000000);
   endtask

   // Random widths: mostly whole images, some cut short by a new write
   task automatic test_random_images(input int budget);
      int sent, count, sel, i;
      logic [CFG_W-1:0] cfg;
      sent = 0;
      while (sent < budget) begin
         sel = $urandom_range(19);
         if (sel == 0) begin
            cfg = 4'd0;
            count = $urandom_range(1, 4);
         end else if (sel == 1) begin
            cfg = CFG_W'($urandom_range(9, 15));
            count = $urandom_range(2, 6);
         end else if (sel <= 3) begin
            cfg = CFG_W'($urandom_range(5, 8));
            count = $urandom_range(2, 10);
         end else if (sel <= 6) begin
            cfg = 4'd1;
            count = 4 * $urandom_range(1, 2);
         end else if (sel <= 12) begin
            cfg = 4'd2;
            count = 16;
         end else if (sel <= 17) begin
            cfg = 4'd3;
            count = 64;
         end else begin
            // broken image: restarted by the next write
            cfg = CFG_W'($urandom_range(1, 3));
            count = $urandom_range(1, (1 << (2 * cfg)) - 1);
         end
         write_width(cfg);
         for (i = 0; i < count; i++)
            send_pixel(random_pixel());
         sent += count;
      end
   endtask

   // Full 16x16 image with a long receiver hold-off part way through
   task automatic test_backpressure_image();
      int i;
      write_width(4'd4);
      for (i = 0; i < 256; i++) begin
         if (i == 24)
            hold_request = 200;
         send_pixel(random_pixel());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 16;
      recv_stall_pct = 51;
      test_reset_width();
      test_single_pixel();
      test_oversized_width();
      test_box_average();
      test_random_images(35);

      send_idle_pct  = 51;
      recv_stall_pct = 16;
      test_random_images(35);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_backpressure_image();

      drain_block();
      $display("Sent %0d source pixels and checked %0d mip pixels up to level %0d,",
               pixels_sent, results_seen, top_level_seen);
      $display("over widths 0 to 15, with stalls on both sides and one long hold-off.");
      if (mismatches == 0 && mip_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatches, mip_expected.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
